### design/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication under reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### design/ssdma_pkg.sv
package ssdma_pkg;

	localparam logic [15:0] SPRITE_TRIGGER_ADDR = 16'h4014;
	localparam logic [15:0] SPRITE_DATA_ADDR    = 16'h2004;

	// sprite copy sequencer, one-hot
	typedef enum logic [3:0] {
		SP_IDLE  = 4'b0001,
		SP_ARMED = 4'b0010,
		SP_READ  = 4'b0100,
		SP_WRITE = 4'b1000
	} sprite_state_t;

	// sample fetch sequencer, one-hot
	typedef enum logic [3:0] {
		SM_IDLE  = 4'b0001,
		SM_ARMED = 4'b0010,
		SM_DUMMY = 4'b0100,
		SM_READ  = 4'b1000
	} sample_state_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] cpu_address;
		logic [7:0]  cpu_write_data;
		logic        sample_request;
		logic [15:0] sample_address;
		logic [7:0]  bus_read_data;
	} item_t;

	typedef struct packed {
		logic        bus_is_write;
		logic [15:0] bus_address;
		logic [7:0]  bus_write_data;
		logic        cpu_access_done;
		logic        sample_byte_valid;
		logic [7:0]  sample_byte;
	} result_t;

	typedef struct packed {
		logic          cycle_parity;
		sprite_state_t sprite_copy_state;
		sample_state_t sample_fetch_state;
		logic [7:0]    sprite_source_page;
		logic [7:0]    sprite_byte_index;
		logic          dma_active;
		logic          sample_read_issued;
	} dma_state_t;

	// a request only arms an idle fetch
	function automatic sample_state_t take_request(logic req, sample_state_t cur);
		sample_state_t res;
		res = cur;
		if (req && cur == SM_IDLE) begin
			res = SM_ARMED;
		end
		return res;
	endfunction

endpackage

### design/ssdma_item_if.sv
interface ssdma_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] cpu_address;
	logic [7:0]  cpu_write_data;
	logic        sample_request;
	logic [15:0] sample_address;
	logic [7:0]  bus_read_data;

	modport source (
		output valid, operation, cpu_address, cpu_write_data,
		output sample_request, sample_address, bus_read_data,
		input ready
	);
	modport sink (
		input valid, operation, cpu_address, cpu_write_data,
		input sample_request, sample_address, bus_read_data,
		output ready
	);
endinterface

### design/ssdma_result_if.sv
interface ssdma_result_if;
	logic        valid;
	logic        ready;
	logic        bus_is_write;
	logic [15:0] bus_address;
	logic [7:0]  bus_write_data;
	logic        cpu_access_done;
	logic        sample_byte_valid;
	logic [7:0]  sample_byte;

	modport source (
		output valid, bus_is_write, bus_address, bus_write_data,
		output cpu_access_done, sample_byte_valid, sample_byte,
		input ready
	);
	modport sink (
		input valid, bus_is_write, bus_address, bus_write_data,
		input cpu_access_done, sample_byte_valid, sample_byte,
		output ready
	);
endinterface

### design/ssdma_step.sv
module ssdma_step (
	input  ssdma_pkg::item_t      it,
	input  ssdma_pkg::dma_state_t cur,
	output ssdma_pkg::dma_state_t nxt,
	output ssdma_pkg::result_t    res
);

	logic get;
	logic used;

	assign get = ~cur.cycle_parity;

	// one bus cycle decision
	always_comb begin
		nxt = cur;
		res = '0;
		res.bus_address = it.cpu_address;
		used = 1'b0;

		// sample byte returns with the item after its read
		if (cur.sample_read_issued) begin
			res.sample_byte_valid = 1'b1;
			res.sample_byte = it.bus_read_data;
			nxt.sample_read_issued = 1'b0;
		end

		if (!cur.dma_active) begin
			if (it.operation) begin
				// cpu write passes through, may arm a sprite copy or a sample fetch
				res.bus_is_write = 1'b1;
				res.bus_write_data = it.cpu_write_data;
				res.cpu_access_done = 1'b1;
				if (it.cpu_address == ssdma_pkg::SPRITE_TRIGGER_ADDR) begin
					nxt.sprite_copy_state = ssdma_pkg::SP_ARMED;
					nxt.sprite_source_page = it.cpu_write_data;
				end
				nxt.sample_fetch_state = ssdma_pkg::take_request(it.sample_request,
					cur.sample_fetch_state);
			end else begin
				// cpu read: halt if anything is armed
				nxt.sample_fetch_state = ssdma_pkg::take_request(it.sample_request,
					cur.sample_fetch_state);
				if (cur.sprite_copy_state != ssdma_pkg::SP_IDLE ||
					nxt.sample_fetch_state != ssdma_pkg::SM_IDLE) begin
					nxt.dma_active = 1'b1;
					if (nxt.sample_fetch_state == ssdma_pkg::SM_ARMED) begin
						nxt.sample_fetch_state = ssdma_pkg::SM_DUMMY;
					end
					if (cur.sprite_copy_state == ssdma_pkg::SP_ARMED) begin
						nxt.sprite_copy_state = ssdma_pkg::SP_READ;
						nxt.sprite_byte_index = '0;
					end
				end else begin
					res.cpu_access_done = 1'b1;
				end
			end
		end else if (cur.sprite_copy_state == ssdma_pkg::SP_IDLE &&
			cur.sample_fetch_state == ssdma_pkg::SM_IDLE) begin
			// halt ends, cpu read repeated
			res.cpu_access_done = 1'b1;
			nxt.dma_active = 1'b0;
			nxt.sample_fetch_state = ssdma_pkg::take_request(it.sample_request,
				cur.sample_fetch_state);
		end else begin
			// sample fetch has priority on get cycles
			case (cur.sample_fetch_state)
				ssdma_pkg::SM_ARMED: begin
					nxt.sample_fetch_state = ssdma_pkg::SM_DUMMY;
				end
				ssdma_pkg::SM_DUMMY: begin
					nxt.sample_fetch_state = ssdma_pkg::SM_READ;
				end
				ssdma_pkg::SM_READ: begin
					if (get) begin
						res.bus_address = it.sample_address;
						nxt.sample_read_issued = 1'b1;
						used = 1'b1;
						nxt.sample_fetch_state = ssdma_pkg::SM_IDLE;
					end
				end
				default: begin
				end
			endcase

			// sprite copy: read on get, write to the data port on put
			case (cur.sprite_copy_state)
				ssdma_pkg::SP_ARMED: begin
					nxt.sprite_copy_state = ssdma_pkg::SP_READ;
					nxt.sprite_byte_index = '0;
				end
				ssdma_pkg::SP_READ: begin
					if (!used && get) begin
						res.bus_address = {cur.sprite_source_page, cur.sprite_byte_index};
						used = 1'b1;
						nxt.sprite_copy_state = ssdma_pkg::SP_WRITE;
					end
				end
				ssdma_pkg::SP_WRITE: begin
					if (!used && !get) begin
						res.bus_is_write = 1'b1;
						res.bus_address = ssdma_pkg::SPRITE_DATA_ADDR;
						res.bus_write_data = it.bus_read_data;
						used = 1'b1;
						nxt.sprite_byte_index = cur.sprite_byte_index + 8'd1;
						if (cur.sprite_byte_index == 8'hFF) begin
							nxt.sprite_copy_state = ssdma_pkg::SP_IDLE;
						end else begin
							nxt.sprite_copy_state = ssdma_pkg::SP_READ;
						end
					end
				end
				default: begin
				end
			endcase

			nxt.sample_fetch_state = ssdma_pkg::take_request(it.sample_request,
				nxt.sample_fetch_state);
		end

		nxt.cycle_parity = ~cur.cycle_parity;
	end

endmodule

### design/sprite_and_sample_dma_bus_controller_core.sv
// one input register and one result register around the single-pass decision
// logic; an item beat is accepted, then its result beat is registered; one item
// per cycle; both registers stall only while result.ready is low
// reset: arst_n clears the dma state, parity to a get cycle and both valid flags
module sprite_and_sample_dma_bus_controller_core (
	input logic          clk,
	input logic          arst_n,
	ssdma_item_if.sink   item,
	ssdma_result_if.source result
);

	ssdma_pkg::item_t      item_s1;
	logic                  valid_s1;
	ssdma_pkg::result_t    result_q;
	logic                  result_valid_q;
	ssdma_pkg::dma_state_t state_q;
	ssdma_pkg::dma_state_t state_nxt;
	ssdma_pkg::result_t    result_nxt;
	ssdma_pkg::item_t      item_in;
	logic                  advance;

	assign advance = ~result_valid_q | result.ready;
	assign item.ready = ~valid_s1 | advance;

	assign item_in.operation      = item.operation;
	assign item_in.cpu_address    = item.cpu_address;
	assign item_in.cpu_write_data = item.cpu_write_data;
	assign item_in.sample_request = item.sample_request;
	assign item_in.sample_address = item.sample_address;
	assign item_in.bus_read_data  = item.bus_read_data;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item_in;
		end
	end

	ssdma_step u_step (
		.it  (item_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.res (result_nxt)
	);

	// dma state advances once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cycle_parity       <= 1'b0;
			state_q.sprite_copy_state  <= ssdma_pkg::SP_IDLE;
			state_q.sample_fetch_state <= ssdma_pkg::SM_IDLE;
			state_q.sprite_source_page <= '0;
			state_q.sprite_byte_index  <= '0;
			state_q.dma_active         <= 1'b0;
			state_q.sample_read_issued <= 1'b0;
			result_valid_q             <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result_nxt;
		end
	end

	assign result.valid             = result_valid_q;
	assign result.bus_is_write      = result_q.bus_is_write;
	assign result.bus_address       = result_q.bus_address;
	assign result.bus_write_data    = result_q.bus_write_data;
	assign result.cpu_access_done   = result_q.cpu_access_done;
	assign result.sample_byte_valid = result_q.sample_byte_valid;
	assign result.sample_byte       = result_q.sample_byte;

endmodule

### design/ssdma_checker.sv
`include "assert_macros.svh"

module ssdma_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        bus_is_write,
	input logic [15:0] bus_address,
	input logic [7:0]  bus_write_data,
	input logic        cpu_access_done,
	input logic        sample_byte_valid,
	input logic [7:0]  sample_byte
);

	// a stalled result beat holds its address, write data and done flag
	`ASSERT_NEXT(a_stall_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(bus_address) && $stable(bus_write_data) && $stable(cpu_access_done))

	// reads drive no write data
	`ASSERT_IMPLY(a_read_no_data, clk, arst_n, res_valid && !bus_is_write, bus_write_data == 8'h00)

	// sample byte is zero unless flagged
	`ASSERT_IMPLY(a_sample_clean, clk, arst_n, res_valid && !sample_byte_valid, sample_byte == 8'h00)

	// the only dma write goes to the sprite data port
	`ASSERT_IMPLY(a_dma_write_port, clk, arst_n, res_valid && bus_is_write && !cpu_access_done, bus_address == ssdma_pkg::SPRITE_DATA_ADDR)

endmodule

bind sprite_and_sample_dma_bus_controller_core ssdma_checker u_ssdma_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.bus_is_write      (result.bus_is_write),
	.bus_address       (result.bus_address),
	.bus_write_data    (result.bus_write_data),
	.cpu_access_done   (result.cpu_access_done),
	.sample_byte_valid (result.sample_byte_valid),
	.sample_byte       (result.sample_byte)
);
